// File: hw/rtl/spra_pkg.sv
// Shared types and constants of the skin pixel window accumulator.
package spra_pkg;

  // Largest frame dimension; pixels at or beyond it are ignored
  localparam int MAX_FRAME_DIM = 4096;

  localparam int SUM_W = 32;
  localparam int CNT_W = 25;

  localparam logic [SUM_W-1:0] SUM_MAX        = '1;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CNT_W-1:0] MIN_AREA_RESET = 25'd10000;

  // Skin thresholds
  localparam logic [7:0] RED_MIN     = 8'd90;
  localparam logic [7:0] BLUE_MIN    = 8'd45;
  localparam logic [8:0] SPREAD_MIN  = 9'd35;
  localparam logic [8:0] RG_DIFF_MIN = 9'd25;

  // Reciprocal of 13 scaled by 2^17, exact floor for 13-bit values
  localparam logic [13:0] RECIP13       = 14'd10083;
  localparam int          RECIP13_SHIFT = 17;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WINDOW_LEFT   = 3'd0,
    REG_WINDOW_TOP    = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_GREY_MODE     = 3'd4,
    REG_MIN_AREA      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        frame_end;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] skin_area;
    logic             face_found;
  } result_t;

  // Register file contents plus values derived at write time
  typedef struct packed {
    logic [11:0]      left;
    logic [11:0]      top;
    logic [12:0]      width;
    logic [12:0]      height;
    logic             grey;
    logic [CNT_W-1:0] min_area;
    logic [9:0]       ext;
    logic [11:0]      ext5;
    logic [12:0]      span;
  } cfg_t;

  // Classified pixel handed to the accumulators
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       hit;
    logic       count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

endpackage

// File: hw/rtl/spra_cfg.sv
// Configuration registers with the derived window extension and grey span.
module spra_cfg import spra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data,
  output cfg_t        cfg
);

  logic [26:0] ext_prod;
  logic [9:0]  ext_next;
  logic [12:0] width_w;
  logic [12:0] span_next;

  assign cfg_ready = 1'b1;

  // Height / 13 by reciprocal, times five by shift and add
  assign ext_prod  = 27'(cfg_data[12:0]) * 27'(RECIP13);
  assign ext_next  = ext_prod[RECIP13_SHIFT +: 10];

  // Grey span: W - 2*(W/4)
  assign width_w   = cfg_data[12:0];
  assign span_next = width_w - {1'b0, width_w[12:2], 1'b0};

  // Write one register per word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left     <= '0;
      cfg.top      <= '0;
      cfg.width    <= '0;
      cfg.height   <= '0;
      cfg.grey     <= 1'b0;
      cfg.min_area <= MIN_AREA_RESET;
      cfg.ext      <= '0;
      cfg.ext5     <= '0;
      cfg.span     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LEFT:   cfg.left <= cfg_data[11:0];
        REG_WINDOW_TOP:    cfg.top  <= cfg_data[11:0];
        REG_WINDOW_WIDTH: begin
          cfg.width <= width_w;
          cfg.span  <= span_next;
        end
        REG_WINDOW_HEIGHT: begin
          cfg.height <= cfg_data[12:0];
          cfg.ext    <= ext_next;
          cfg.ext5   <= {ext_next, 2'b00} + 12'(ext_next);
        end
        REG_GREY_MODE:     cfg.grey     <= cfg_data[0];
        REG_MIN_AREA:      cfg.min_area <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/spra_classify.sv
// Input register, window test and skin test for one pixel.
module spra_classify import spra_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  input  cfg_t   cfg,
  input  logic   take,
  output item_t  item
);

  logic        s1_valid;
  pixel_t      s1_pix;
  logic        accept;
  logic [13:0] right;
  logic [13:0] bottom;
  logic [11:0] top_lo;
  logic        in_frame;
  logic        in_win;
  logic [7:0]  lo;
  logic [8:0]  spread;
  logic [8:0]  rg_diff;
  logic        skin;

  assign pixel_stall = s1_valid && !take;
  assign accept      = pixel_valid && !pixel_stall;

  // Hold the pixel until the accumulators take it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel;
    end
  end

  // Window bounds at full width, top clamped at row zero
  assign right    = 14'(cfg.left) + 14'(cfg.width);
  assign bottom   = 14'(cfg.top) + 14'(cfg.height);
  assign top_lo   = (cfg.top >= 12'(cfg.ext)) ? cfg.top - 12'(cfg.ext) : '0;
  assign in_frame = (14'(s1_pix.pixel_col) < 14'(MAX_FRAME_DIM)) &&
                    (14'(s1_pix.pixel_row) < 14'(MAX_FRAME_DIM));
  assign in_win   = in_frame &&
                    (s1_pix.pixel_col >= cfg.left) && (14'(s1_pix.pixel_col) < right) &&
                    (s1_pix.pixel_row >= top_lo)   && (14'(s1_pix.pixel_row) < bottom);

  // Skin rule: R > 90, R > G, B > 45, R - min(G,B) > 35, R - G > 25
  assign lo      = (s1_pix.pixel_green < s1_pix.pixel_blue) ?
                   s1_pix.pixel_green : s1_pix.pixel_blue;
  assign spread  = 9'(s1_pix.pixel_red) - 9'(lo);
  assign rg_diff = 9'(s1_pix.pixel_red) - 9'(s1_pix.pixel_green);
  assign skin    = (s1_pix.pixel_red > RED_MIN) &&
                   (s1_pix.pixel_red > s1_pix.pixel_green) &&
                   (s1_pix.pixel_blue > BLUE_MIN) &&
                   (spread > SPREAD_MIN) && (rg_diff > RG_DIFF_MIN);

  // Grey mode sums the green channel over the whole window and counts nothing
  always_comb begin
    item.valid = s1_valid;
    item.last  = s1_pix.frame_end;
    if (cfg.grey) begin
      item.hit   = in_win;
      item.count = 1'b0;
      item.red   = s1_pix.pixel_green;
      item.green = s1_pix.pixel_green;
      item.blue  = s1_pix.pixel_green;
    end else begin
      item.hit   = in_win && skin;
      item.count = in_win && skin;
      item.red   = s1_pix.pixel_red;
      item.green = s1_pix.pixel_green;
      item.blue  = s1_pix.pixel_blue;
    end
  end

endmodule

// File: hw/rtl/spra_accum.sv
// Saturating sums, skin count and the result register.
module spra_accum import spra_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    take,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [SUM_W-1:0] red_total;
  logic [SUM_W-1:0] green_total;
  logic [SUM_W-1:0] blue_total;
  logic [CNT_W-1:0] accepted_count;

  logic [SUM_W:0]   red_wide;
  logic [SUM_W:0]   green_wide;
  logic [SUM_W:0]   blue_wide;
  logic [SUM_W-1:0] red_next;
  logic [SUM_W-1:0] green_next;
  logic [SUM_W-1:0] blue_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] area_grey;
  logic [CNT_W-1:0] area;
  logic             step;
  logic             load;

  // A frame end waits while the previous result is still pending
  assign take = !(item.last && result_valid && result_stall);
  assign step = item.valid && take;
  assign load = step && item.last;

  assign red_wide   = {1'b0, red_total}   + (SUM_W+1)'(item.red);
  assign green_wide = {1'b0, green_total} + (SUM_W+1)'(item.green);
  assign blue_wide  = {1'b0, blue_total}  + (SUM_W+1)'(item.blue);

  // Clamp the sums and the count at their maximum
  always_comb begin
    red_next   = red_total;
    green_next = green_total;
    blue_next  = blue_total;
    count_next = accepted_count;
    if (item.hit) begin
      red_next   = red_wide[SUM_W]   ? SUM_MAX : red_wide[SUM_W-1:0];
      green_next = green_wide[SUM_W] ? SUM_MAX : green_wide[SUM_W-1:0];
      blue_next  = blue_wide[SUM_W]  ? SUM_MAX : blue_wide[SUM_W-1:0];
    end
    if (item.count && (accepted_count != CNT_MAX)) begin
      count_next = accepted_count + 1'b1;
    end
  end

  // Grey area is span times five rows per thirteenth of height
  assign area_grey = CNT_W'(cfg.span) * CNT_W'(cfg.ext5);
  assign area      = cfg.grey ? area_grey : count_next;

  // Advance totals, clear them on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      red_total      <= '0;
      green_total    <= '0;
      blue_total     <= '0;
      accepted_count <= '0;
    end else if (load) begin
      red_total      <= '0;
      green_total    <= '0;
      blue_total     <= '0;
      accepted_count <= '0;
    end else if (step) begin
      red_total      <= red_next;
      green_total    <= green_next;
      blue_total     <= blue_next;
      accepted_count <= count_next;
    end
  end

  // Hold the result word until downstream takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= load || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.red_sum    <= red_next;
      result.green_sum  <= green_next;
      result.blue_sum   <= blue_next;
      result.skin_area  <= area;
      result.face_found <= area > cfg.min_area;
    end
  end

endmodule

// File: hw/rtl/skin_pixel_roi_accumulator_top.sv
// Top level of the skin pixel window accumulator.
//
//   channel   direction  handshake             word
//   pixel     in         pixel_valid/stall     pixel_t: position, color, frame end
//   result    out        result_valid/stall    result_t: sums, area, face flag
//   cfg       in         cfg_valid/ready       cfg_index, cfg_data
//
// One pixel is accepted every cycle while pixel_stall is low. A pixel is held
// in the input register until the accumulators take it; the result word for
// a frame-end pixel is loaded into the result register when that pixel is
// taken, and is held while result_stall is high. pixel_stall rises only when
// a frame-end pixel waits behind a result not yet taken.
// Synchronous reset clears the sums, the count and both valid flags and
// returns the registers to their defaults; cfg_ready is always high.
module skin_pixel_roi_accumulator_top import spra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pixel_t      pixel,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  take;

  spra_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spra_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cfg         (cfg),
    .take        (take),
    .item        (item)
  );

  spra_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: hw/rtl/spra_checker.sv
// Port-level checks on the accumulator top, bound into it.
module spra_checker import spra_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pixel_valid,
  input logic    pixel_stall,
  input pixel_t  pixel,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("pixel stall without a pending result");

  // A new result follows an accepted frame-end pixel
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_valid && !pixel_stall && pixel.frame_end, 2))
    else $error("result without a frame end pixel");

endmodule

bind skin_pixel_roi_accumulator_top spra_checker u_spra_checker (.*);

// File: tb/skin_pixel_roi_accumulator_checker.sv
// Checker for the skin pixel window accumulator: frame sum prediction and result compare.
`timescale 1ns / 100ps

module skin_pixel_roi_accumulator_checker import spra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  input  logic        pixel_stall,
  input  pixel_t      pixel,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data,
  output int          fail_count,
  output int          pending_frames
);

  // Skin rule thresholds and window geometry factors
  localparam int unsigned RED_FLOOR    = 90;
  localparam int unsigned BLUE_FLOOR   = 45;
  localparam int unsigned SPREAD_FLOOR = 35;
  localparam int unsigned RG_GAP_FLOOR = 25;
  localparam int unsigned EXT_DIV      = 13;
  localparam int unsigned TRIM_DIV     = 4;
  localparam int unsigned EXT_ROWS_MUL = 5;
  localparam int unsigned AREA_MAX     = (1 << CNT_W) - 1;

  // Shadow copy of the register file
  logic [11:0]      win_left;
  logic [11:0]      win_top;
  logic [12:0]      win_width;
  logic [12:0]      win_height;
  logic             grey;
  logic [CNT_W-1:0] min_area;

  // Running frame totals
  logic [SUM_W-1:0] red_acc;
  logic [SUM_W-1:0] green_acc;
  logic [SUM_W-1:0] blue_acc;
  logic [CNT_W-1:0] skin_count;

  result_t frame_totals_q[$];

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [7:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + v;
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin : track
    result_t     want;
    int unsigned ext, row_first, row_end, col_end, area, span;
    int unsigned r, g, b, lo;
    if (rst) begin
      win_left   = '0;
      win_top    = '0;
      win_width  = '0;
      win_height = '0;
      grey       = 1'b0;
      min_area   = MIN_AREA_RESET;
      red_acc    = '0;
      green_acc  = '0;
      blue_acc   = '0;
      skin_count = '0;
      frame_totals_q.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEFT:   win_left   = cfg_data[11:0];
          REG_WINDOW_TOP:    win_top    = cfg_data[11:0];
          REG_WINDOW_WIDTH:  win_width  = cfg_data[12:0];
          REG_WINDOW_HEIGHT: win_height = cfg_data[12:0];
          REG_GREY_MODE:     grey       = cfg_data[0];
          REG_MIN_AREA:      min_area   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      // Compare each result word with the oldest frame totals
      if (result_valid && !result_stall) begin
        if (frame_totals_q.size() == 0) begin
          $error("result word with no frame pending");
          fail_count++;
        end else begin
          want = frame_totals_q.pop_front();
          if (result.red_sum !== want.red_sum) begin
            $error("red_sum: expected %0d, got %0d", want.red_sum, result.red_sum);
            fail_count++;
          end
          if (result.green_sum !== want.green_sum) begin
            $error("green_sum: expected %0d, got %0d", want.green_sum, result.green_sum);
            fail_count++;
          end
          if (result.blue_sum !== want.blue_sum) begin
            $error("blue_sum: expected %0d, got %0d", want.blue_sum, result.blue_sum);
            fail_count++;
          end
          if (result.skin_area !== want.skin_area) begin
            $error("skin_area: expected %0d, got %0d", want.skin_area, result.skin_area);
            fail_count++;
          end
          if (result.face_found !== want.face_found) begin
            $error("face_found: expected %0d, got %0d", want.face_found, result.face_found);
            fail_count++;
          end
        end
      end

      // Accumulate each pixel word against the registers that hold now
      if (pixel_valid && !pixel_stall) begin
        ext       = win_height / EXT_DIV;
        row_first = (win_top >= ext) ? win_top - ext : 0;
        row_end   = win_top + win_height;
        col_end   = win_left + win_width;
        r  = pixel.pixel_red;
        g  = pixel.pixel_green;
        b  = pixel.pixel_blue;
        lo = (g < b) ? g : b;
        if (pixel.pixel_col >= win_left && pixel.pixel_col < col_end &&
            pixel.pixel_row >= row_first && pixel.pixel_row < row_end) begin
          if (grey) begin
            red_acc   = sat_add(red_acc, pixel.pixel_green);
            green_acc = sat_add(green_acc, pixel.pixel_green);
            blue_acc  = sat_add(blue_acc, pixel.pixel_green);
          end else if (r > RED_FLOOR && r > g && b > BLUE_FLOOR &&
                       r - lo > SPREAD_FLOOR && r - g > RG_GAP_FLOOR) begin
            red_acc   = sat_add(red_acc, pixel.pixel_red);
            green_acc = sat_add(green_acc, pixel.pixel_green);
            blue_acc  = sat_add(blue_acc, pixel.pixel_blue);
            if (skin_count != CNT_MAX) skin_count = skin_count + 1'b1;
          end
        end

        // Close the frame: queue its totals and clear
        if (pixel.frame_end) begin
          if (grey) begin
            span = win_width - 2 * (win_width / TRIM_DIV);
            area = span * (EXT_ROWS_MUL * ext);
            if (area > AREA_MAX) area = AREA_MAX;
          end else begin
            area = skin_count;
          end
          want.red_sum    = red_acc;
          want.green_sum  = green_acc;
          want.blue_sum   = blue_acc;
          want.skin_area  = area[CNT_W-1:0];
          want.face_found = (area > min_area);
          frame_totals_q.push_back(want);
          red_acc    = '0;
          green_acc  = '0;
          blue_acc   = '0;
          skin_count = '0;
        end
      end
    end
    pending_frames = frame_totals_q.size();
  end

endmodule

// File: tb/skin_pixel_roi_accumulator_top_test.sv
// Testbench top for the skin pixel window accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module skin_pixel_roi_accumulator_top_test import spra_pkg::*;;

  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pixel_t      pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_WINDOW_LEFT;
  logic [24:0] cfg_data = '0;

  int fail_count;
  int pending_frames;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  skin_pixel_roi_accumulator_top uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  skin_pixel_roi_accumulator_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel          (pixel),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_frames (pending_frames)
  );

  always #2 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold one pixel word until it is taken
  task automatic send_pixel(int unsigned col, int unsigned row, int unsigned red,
                            int unsigned green, int unsigned blue, bit last);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid       <= 1'b1;
    pixel.pixel_col   <= col[11:0];
    pixel.pixel_row   <= row[11:0];
    pixel.pixel_red   <= red[7:0];
    pixel.pixel_green <= green[7:0];
    pixel.pixel_blue  <= blue[7:0];
    pixel.frame_end   <= last;
    do begin
      @(negedge clk);
      took = !pixel_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Drop valid, wait for every pending frame, then let the pipeline empty
  task automatic settle();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending_frames != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[24:0];
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Write the whole register file while the block is idle
  task automatic configure(int unsigned left, int unsigned top, int unsigned width,
                           int unsigned height, int unsigned grey, int unsigned min_area);
    settle();
    write_reg(REG_WINDOW_LEFT, left);
    write_reg(REG_WINDOW_TOP, top);
    write_reg(REG_WINDOW_WIDTH, width);
    write_reg(REG_WINDOW_HEIGHT, height);
    write_reg(REG_GREY_MODE, grey);
    write_reg(REG_MIN_AREA, min_area);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned left, top, width, height, grey, min_area, ext;
    int unsigned col_lo, col_hi, row_lo, row_hi, col, row, red, green, blue;
    bit last;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: window rows 47..88, columns 100..139, colour mode
    configure(100, 50, 40, 39, 0, 1);
    send_pixel(100, 47, 91, 65, 46, 1'b0);     // just passes the red, blue and red-green skin bounds
    send_pixel(139, 88, 255, 0, 255, 1'b0);    // far corner of the window
    send_pixel(99, 60, 200, 60, 100, 1'b0);    // left of window
    send_pixel(140, 60, 200, 60, 100, 1'b0);   // right of window
    send_pixel(120, 46, 200, 60, 100, 1'b0);   // above the extended top
    send_pixel(120, 89, 200, 60, 100, 1'b0);   // below the bottom
    send_pixel(120, 60, 90, 0, 255, 1'b0);     // red too low
    send_pixel(120, 60, 91, 66, 46, 1'b0);     // red-green gap too small
    send_pixel(120, 60, 200, 10, 45, 1'b0);    // blue too low
    send_pixel(120, 60, 100, 70, 65, 1'b0);    // spread too small
    send_pixel(4095, 4095, 0, 0, 0, 1'b1);

    // Switch to grey mode in the middle of a frame
    send_pixel(110, 60, 150, 80, 100, 1'b0);
    configure(100, 50, 40, 39, 1, 0);
    send_pixel(110, 60, 0, 255, 0, 1'b0);
    send_pixel(4095, 0, 255, 0, 255, 1'b1);

    // No face: empty window
    configure(100, 50, 0, 39, 0, 0);
    send_pixel(100, 50, 255, 0, 255, 1'b0);
    send_pixel(0, 0, 255, 0, 255, 1'b1);

    // Frame-sized window at the far corner, grey, threshold of 2^24
    configure(4095, 4095, 4096, 4096, 1, 16777216);
    send_pixel(4095, 3780, 0, 255, 0, 1'b1);
    send_pixel(4095, 3779, 0, 255, 0, 1'b1);

    // Full frame window with the top clamped at row zero
    configure(0, 0, 4096, 4096, 0, 0);
    send_pixel(0, 0, 255, 0, 255, 1'b0);
    send_pixel(4095, 4095, 255, 0, 255, 1'b1);

    // Random phases, each with its own window and one of four idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      left     = $urandom_range(4095);
      top      = $urandom_range(4095);
      width    = $urandom_range(64, 1);
      height   = $urandom_range(80, 0);
      grey     = $urandom_range(1);
      min_area = grey ? $urandom_range(1000) : $urandom_range(40);
      case (phase)
        2: begin
          left = 0; top = 0; width = 4096; height = 4096; grey = 0; min_area = 16777216;
        end
        3: width = 0;
        4: begin
          left = 4095; top = 4095; min_area = 0;
        end
        default: ;
      endcase
      configure(left, top, width, height, grey, min_area);

      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase

      // Aim most pixels at the window and a margin around it
      ext    = height / 13;
      col_lo = (left > 2) ? left - 2 : 0;
      col_hi = (left + width + 1 > 4095) ? 4095 : left + width + 1;
      row_lo = (top > ext + 2) ? top - ext - 2 : 0;
      row_hi = (top + height + 1 > 4095) ? 4095 : top + height + 1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        col = ($urandom_range(3) != 0) ? $urandom_range(col_hi, col_lo) : $urandom_range(4095);
        row = ($urandom_range(3) != 0) ? $urandom_range(row_hi, row_lo) : $urandom_range(4095);
        if ($urandom_range(1)) begin
          red   = $urandom_range(255, 80);
          green = $urandom_range(red, 0);
          blue  = $urandom_range(255, 30);
        end else begin
          red   = $urandom_range(255);
          green = $urandom_range(255);
          blue  = $urandom_range(255);
        end
        last = ($urandom_range(9) == 0);
        send_pixel(col, row, red, green, blue, last);
        if ($urandom_range(19) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0 && pending_frames == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
